### src/tgr_pkg.sv
package tgr_pkg;

  localparam int unsigned ADDR_BITS = 22;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned PROD_W = 2 * COORD_W;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_CHAR = 2'd2;

  localparam logic [7:0] CODE_END = 8'd0;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;

  localparam logic [COORD_W-1:0] GLYPH_WIDTH = 12'd8;
  localparam logic [COORD_W-1:0] LINE_STEP = 12'd20;

  localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] CFG_TEXT_COLOUR = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

  localparam logic [COORD_W-1:0] LINE_WIDTH_RST = 12'd320;
  localparam logic [7:0] TEXT_COLOUR_RST = 8'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [11:0] font_index;
    logic [7:0]  font_byte;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] pixel_address;
    logic [7:0]           pixel_mask;
    logic [7:0]           pixel_colour;
    logic                 last_row;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic newline;
    logic glyph;
    logic reduce;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic reduced;
    logic emit_done;
  } dp_status_t;

endpackage

### src/text_glyph_renderer.sv
// a glyph's first row passes the REDUCE state (repeated per font-wrap reduction step),
// the font ram read register and the output register; then one row per cycle, unless
// the output stalls, through the single ram read port; a glyph blocks the input until
// its last row is registered; load, start, newline and end items never block it
// reset: config registers to defaults, cursor to zero, output empty; font ram not cleared
module text_glyph_renderer import tgr_pkg::*; #(
  parameter int unsigned GLYPH_ROWS = 16,
  parameter int unsigned FONT_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_data_i.action),
    .char_code_i (in_data_i.char_code),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  tgr_datapath #(
    .GLYPH_ROWS(GLYPH_ROWS),
    .FONT_BYTES(FONT_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/tgr_ram.sv
module tgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/tgr_ctrl.sv
module tgr_ctrl import tgr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] action_i,
  input  logic [7:0] char_code_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       in_stall_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_LOAD: begin
              cmd_o.load = 1'b1;
            end
            ACT_START: begin
              cmd_o.start = 1'b1;
            end
            ACT_CHAR: begin
              if (char_code_i == CODE_NEWLINE) begin
                cmd_o.newline = 1'b1;
              end else if (char_code_i != CODE_END) begin
                cmd_o.glyph = 1'b1;
                state_d = ST_REDUCE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (status_i.reduced) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### src/tgr_datapath.sv
module tgr_datapath import tgr_pkg::*; #(
  parameter int unsigned GLYPH_ROWS = 16,
  parameter int unsigned FONT_BYTES = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  in_item_t     in_data_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [11:0]  cfg_data_i,
  input  dp_cmd_t      cmd_i,
  output dp_status_t   status_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_item_t    out_data_o
);

  localparam int unsigned FA_W = $clog2(FONT_BYTES);
  localparam int unsigned GP_W = $clog2(256 * GLYPH_ROWS);
  localparam int unsigned SW = ((GP_W > FA_W) ? GP_W : FA_W) + 1;
  localparam int unsigned RC_W = $clog2(GLYPH_ROWS + 1);

  logic [COORD_W-1:0] line_width_q, origin_x_q, origin_y_q;
  logic [7:0]         colour_q;
  logic [COORD_W-1:0] cursor_x_q, cursor_y_q;
  logic [COORD_W:0]   next_x;

  logic [PROD_W-1:0]    prod_q;
  logic [COORD_W-1:0]   cx_q;
  logic [SW-1:0]        fa_q, fa_inc;
  logic [ADDR_BITS-1:0] addr_q, pend_addr_q;
  logic [RC_W-1:0]      rq_q;
  logic                 pend_q, pend_last_q;
  logic                 issue, advance, font_we;
  logic [7:0]           ram_rdata;

  out_item_t out_q;
  logic      out_valid_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      colour_q <= TEXT_COLOUR_RST;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_WIDTH:  line_width_q <= cfg_data_i;
        CFG_TEXT_COLOUR: colour_q <= cfg_data_i[7:0];
        CFG_ORIGIN_X:    origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y:    origin_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // text cursor
  assign next_x = {1'b0, cursor_x_q} + {1'b0, GLYPH_WIDTH};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else if (cmd_i.start) begin
      cursor_x_q <= origin_x_q;
      cursor_y_q <= origin_y_q;
    end else if (cmd_i.newline) begin
      cursor_x_q <= origin_x_q;
      cursor_y_q <= cursor_y_q + LINE_STEP;
    end else if (cmd_i.glyph) begin
      if (next_x > {1'b0, line_width_q}) begin
        cursor_x_q <= GLYPH_WIDTH;
        cursor_y_q <= cursor_y_q + LINE_STEP;
      end else begin
        cursor_x_q <= next_x[COORD_W-1:0];
      end
    end
  end

  // glyph address setup
  assign fa_inc = fa_q + SW'(1);
  assign status_o.reduced = (fa_q < SW'(FONT_BYTES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.glyph) begin
      prod_q <= PROD_W'(cursor_y_q) * PROD_W'(line_width_q);
      cx_q <= cursor_x_q;
      fa_q <= SW'(in_data_i.char_code) * SW'(GLYPH_ROWS);
    end else if (cmd_i.reduce) begin
      addr_q <= ADDR_BITS'((PROD_W + 1)'(prod_q) + (PROD_W + 1)'(cx_q));
      if (!status_o.reduced) begin
        fa_q <= fa_q - SW'(FONT_BYTES);
      end
    end else if (cmd_i.emit && advance && issue) begin
      addr_q <= addr_q + ADDR_BITS'(line_width_q);
      fa_q <= (fa_inc == SW'(FONT_BYTES)) ? '0 : fa_inc;
      pend_addr_q <= addr_q;
      pend_last_q <= (rq_q == RC_W'(GLYPH_ROWS - 1));
    end
  end

  // row issue and font read
  assign advance = !out_valid_q || !out_stall_i;
  assign issue = (rq_q != RC_W'(GLYPH_ROWS));
  assign status_o.emit_done = !issue && !pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_q <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.glyph) begin
      rq_q <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.emit && advance) begin
      pend_q <= issue;
      if (issue) begin
        rq_q <= rq_q + RC_W'(1);
      end
    end
  end

  assign font_we = cmd_i.load && ({20'd0, in_data_i.font_index} < 32'(FONT_BYTES));

  tgr_ram #(
    .WIDTH(8),
    .DEPTH(FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (FA_W'(in_data_i.font_index)),
    .wdata_i (in_data_i.font_byte),
    .re_i    (cmd_i.emit && advance && issue),
    .raddr_i (fa_q[FA_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= cmd_i.emit && pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && advance && pend_q) begin
      out_q.pixel_address <= pend_addr_q;
      out_q.pixel_mask <= ram_rdata;
      out_q.pixel_colour <= colour_q;
      out_q.last_row <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

### src/tgr_checker.sv
module tgr_checker import tgr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_item_t    in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_item_t   out_data_o
);

  logic in_xfer;
  logic glyph_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign glyph_xfer = in_xfer && (in_data_i.action == ACT_CHAR)
                      && (in_data_i.char_code != CODE_END)
                      && (in_data_i.char_code != CODE_NEWLINE);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a character other than end or newline blocks the input while its rows go out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    glyph_xfer |=> in_stall_o)
    else $error("input open right after glyph transfer");

  // load and start items never block the next transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && ((in_data_i.action == ACT_LOAD) || (in_data_i.action == ACT_START))
    |=> !in_stall_o)
    else $error("input blocked after load or start");

  // rows before the last keep the input closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_row |-> in_stall_o)
    else $error("input open while a glyph is unfinished");

endmodule

bind text_glyph_renderer tgr_checker u_checker (.*);
